FILE: rtl/pmsd_pkg.sv
// Package for the partition maximum-sum prefix engine.
// Holds shared widths, the default part-length limit and the cell control struct.
// No dependencies.
package pmsd_pkg;

   localparam int DEF_MAX_PART_LEN = 16;
   localparam int VALUE_W          = 30;
   localparam int SUM_W            = 48;
   localparam int CFG_W            = 5;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

   typedef struct packed {
      logic accept;
      logic fresh;
      logic calc;
      logic commit;
      logic clear;
   } cell_ctl_type;

endpackage

FILE: rtl/partition_max_sum_dp_core.sv
// Top level of the partition maximum-sum prefix engine.
// Depends on pmsd_pkg, pmsd_cell and pmsd_max_tree.
//
// Each request carries one array element (req_value) and an end-of-array flag
// (req_last). For every request one response returns the best partition total
// of the prefix ending at that element, saturated to 48 bits, with rsp_is_final
// copying the flag. After a final element the window state clears for the next
// array.
// The csr channel writes the largest part length; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce
// this. Zero acts as one, and values above MAX_PART_LEN act as MAX_PART_LEN.
// A request passes the calc state, where the cell row forms its candidates,
// and then the reduce state, where the maximum tree picks the best candidate
// and the new prefix total, which the next element needs, is committed. A new
// request is taken only while idle or in the commit cycle, so the next element
// waits until the previous one has committed.
// Synchronous reset clears the cell windows and prefix totals, the element
// count and rsp_valid, and sets the part length to one. With rsp_ready low, the
// response register holds; a request waiting to commit stalls and req_ready drops.
module partition_max_sum_dp_core #(
   parameter int MAX_PART_LEN = pmsd_pkg::DEF_MAX_PART_LEN
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pmsd_pkg::CFG_W-1:0]         csr_max_part_len,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pmsd_pkg::VALUE_W-1:0]       req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pmsd_pkg::SUM_W-1:0]         rsp_prefix_best,
   output logic                               rsp_is_final
);

   localparam int CNT_W = $clog2(MAX_PART_LEN + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CALC   = 3'b010,
      ST_REDUCE = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [pmsd_pkg::CFG_W-1:0]   cfg_ff, cfg_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pmsd_pkg::SUM_W-1:0]   rsp_best_ff, rsp_best_in;
   logic                         rsp_final_ff, rsp_final_in;

   logic                         accept, out_free, commit;
   logic [pmsd_pkg::SUM_W-1:0]   best;
   pmsd_pkg::cell_ctl_type       ctl;

   logic [MAX_PART_LEN-1:0]                           enable;
   logic [MAX_PART_LEN-1:0][pmsd_pkg::VALUE_W-1:0]    win;
   logic [MAX_PART_LEN-1:0][pmsd_pkg::SUM_W-1:0]      hist;
   logic [MAX_PART_LEN-1:0][pmsd_pkg::SUM_W-1:0]      cand;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_REDUCE) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      ctl.accept = accept;
      ctl.commit = commit;
      ctl.clear  = commit && last_ff;
      ctl.fresh  = commit && last_ff;
      ctl.calc   = (state_ff == ST_CALC);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (commit) begin
               state_in = accept ? ST_CALC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cfg_in   = (csr_valid && csr_ready) ? csr_max_part_len : cfg_ff;
      last_in  = accept ? req_last : last_ff;
      count_in = count_ff;
      if (commit) begin
         if (last_ff) begin
            count_in = '0;
         end else if (count_ff < CNT_W'(MAX_PART_LEN)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_final_in = rsp_final_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = best;
         rsp_final_in = last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= pmsd_pkg::CFG_RESET;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_best_ff  <= rsp_best_in;
      rsp_final_ff <= rsp_final_in;
   end

   genvar k;
   generate
      for (k = 0; k < MAX_PART_LEN; k++) begin : g_cell
         logic [pmsd_pkg::VALUE_W-1:0] prev_win;
         logic [pmsd_pkg::SUM_W-1:0]   prev_hist;

         if (k == 0) begin : g_head
            assign enable[k] = 1'b1;
            assign prev_win  = req_value;
            assign prev_hist = best;
         end else begin : g_body
            assign enable[k] = (32'(k) < 32'(cfg_ff)) && (CNT_W'(k) <= count_ff);
            assign prev_win  = win[k-1];
            assign prev_hist = hist[k-1];
         end

         pmsd_cell #(
            .MAX_PART_LEN (MAX_PART_LEN),
            .INDEX        (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .enable    (enable[k]),
            .value     (req_value),
            .prev_win  (prev_win),
            .prev_hist (prev_hist),
            .win       (win[k]),
            .hist      (hist[k]),
            .cand      (cand[k])
         );
      end
   endgenerate

   pmsd_max_tree #(
      .MAX_PART_LEN (MAX_PART_LEN)
   ) u_max_tree (
      .cands (cand),
      .best  (best)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prefix_best = rsp_best_ff;
   assign rsp_is_final    = rsp_final_ff;

endmodule

FILE: rtl/pmsd_cell.sv
// One cell of the window chain: trailing window maximum, one prefix total, one candidate.
// Depends on pmsd_pkg.
module pmsd_cell #(
   parameter int MAX_PART_LEN = pmsd_pkg::DEF_MAX_PART_LEN,
   parameter int INDEX        = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pmsd_pkg::cell_ctl_type              ctl,
   input  logic                                enable,
   input  logic [pmsd_pkg::VALUE_W-1:0]        value,
   input  logic [pmsd_pkg::VALUE_W-1:0]        prev_win,
   input  logic [pmsd_pkg::SUM_W-1:0]          prev_hist,
   output logic [pmsd_pkg::VALUE_W-1:0]        win,
   output logic [pmsd_pkg::SUM_W-1:0]          hist,
   output logic [pmsd_pkg::SUM_W-1:0]          cand
);

   localparam int LEN_W  = $clog2(MAX_PART_LEN + 1);
   localparam int PROD_W = pmsd_pkg::VALUE_W + LEN_W;
   localparam logic [LEN_W-1:0] PART_LEN = LEN_W'(INDEX + 1);

   logic [pmsd_pkg::VALUE_W-1:0] win_ff, win_in;
   logic [pmsd_pkg::SUM_W-1:0]   hist_ff, hist_in;
   logic [pmsd_pkg::SUM_W-1:0]   cand_ff, cand_in;
   logic [PROD_W-1:0]            prod;
   logic [pmsd_pkg::SUM_W:0]     sum;

   always_comb begin
      win_in = win_ff;
      if (ctl.accept) begin
         if (ctl.fresh || (value > prev_win)) begin
            win_in = value;
         end else begin
            win_in = prev_win;
         end
      end else if (ctl.clear) begin
         win_in = '0;
      end
   end

   always_comb begin
      hist_in = hist_ff;
      if (ctl.commit) begin
         hist_in = ctl.clear ? '0 : prev_hist;
      end
   end

   always_comb begin
      prod    = PROD_W'(win_ff) * PROD_W'(PART_LEN);
      sum     = {1'b0, hist_ff} + (pmsd_pkg::SUM_W + 1)'(prod);
      cand_in = cand_ff;
      if (ctl.calc) begin
         if (!enable) begin
            cand_in = '0;
         end else if (sum[pmsd_pkg::SUM_W]) begin
            cand_in = '1;
         end else begin
            cand_in = sum[pmsd_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         hist_ff <= '0;
      end else begin
         win_ff  <= win_in;
         hist_ff <= hist_in;
      end
      cand_ff <= cand_in;
   end

   assign win  = win_ff;
   assign hist = hist_ff;
   assign cand = cand_ff;

endmodule

FILE: rtl/pmsd_max_tree.sv
// Balanced comparison tree that picks the largest candidate of the cell row.
// Depends on pmsd_pkg.
module pmsd_max_tree #(
   parameter int MAX_PART_LEN = pmsd_pkg::DEF_MAX_PART_LEN
) (
   input  logic [MAX_PART_LEN-1:0][pmsd_pkg::SUM_W-1:0] cands,
   output logic [pmsd_pkg::SUM_W-1:0]                   best
);

   localparam int LEVELS = $clog2(MAX_PART_LEN);
   localparam int LEAVES = 1 << LEVELS;

   logic [pmsd_pkg::SUM_W-1:0] node [2*LEAVES-1];

   genvar i;
   generate
      for (i = 0; i < LEAVES; i++) begin : g_leaf
         if (i < MAX_PART_LEN) begin : g_used
            assign node[LEAVES-1+i] = cands[i];
         end else begin : g_pad
            assign node[LEAVES-1+i] = '0;
         end
      end
      for (i = 0; i < LEAVES - 1; i++) begin : g_node
         assign node[i] = (node[2*i+1] > node[2*i+2]) ? node[2*i+1] : node[2*i+2];
      end
   endgenerate

   assign best = node[0];

endmodule
